>>> hw/rtl/bprd_pkg.sv
// Shared types and constants for the block power ratio core.
package bprd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_BITS   = 43;
    localparam int CNT_BITS      = 13;
    localparam int MSB_BITS      = 6;
    localparam int M_BITS        = 32;
    localparam int LOG_FRAC_BITS = 20;
    localparam int LOG_STAGES    = LOG_FRAC_BITS + 1;
    localparam int LOG_BITS      = MSB_BITS + LOG_FRAC_BITS;
    localparam int DIFF_BITS     = LOG_BITS + 1;
    localparam int SCALE_BITS    = 22;
    localparam int PROD_BITS     = LOG_BITS + SCALE_BITS;
    localparam int DB_SHIFT      = LOG_FRAC_BITS + 16;
    localparam int R_BITS        = PROD_BITS + 1 - DB_SHIFT;
    localparam int OUT_BITS      = 12;
    localparam int FIFO_DEPTH    = 32;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int CREDIT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;
    localparam logic [CNT_BITS-1:0] BLOCK_LEN_RESET = CNT_BITS'(1024);
    // 160*log10(2) in Q16
    localparam logic [SCALE_BITS-1:0] DB_SCALE = SCALE_BITS'(3156528);
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = 12'sh7FF;
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = 12'sh800;
    localparam logic [R_BITS-1:0] R_POS_LIMIT = R_BITS'(2047);
    localparam logic [R_BITS-1:0] R_NEG_LIMIT = R_BITS'(2048);

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_A_ZERO    = 2'd1,
        ST_B_ZERO    = 2'd2,
        ST_BOTH_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic                zero;
        logic [LOG_BITS-1:0] level;
    } lane_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] db;
        status_t                    status;
    } result_t;

endpackage

>>> hw/rtl/bprd_log2_lane.sv
// One log2 lane: leading-one search, normalize, then one squaring step per stage.
module bprd_log2_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             energy_valid,
    input  logic [bprd_pkg::ENERGY_BITS-1:0] energy,
    output logic                             lane_valid,
    output bprd_pkg::lane_t                  lane
);
    import bprd_pkg::*;

    logic                   va_reg;
    logic [ENERGY_BITS-1:0] xa_reg;
    logic [MSB_BITS-1:0]    msba_reg;
    logic [MSB_BITS-1:0]    msb_next;

    logic [MSB_BITS-1:0]    shift;
    logic [ENERGY_BITS-1:0] norm;

    logic [M_BITS-1:0]        m_reg     [LOG_STAGES];
    logic [LOG_FRAC_BITS-1:0] frac_reg  [LOG_STAGES];
    logic [MSB_BITS-1:0]      msb_reg   [LOG_STAGES];
    logic                     zero_reg  [LOG_STAGES];
    logic                     valid_reg [LOG_STAGES];
    logic [2*M_BITS-1:0]      sq        [LOG_FRAC_BITS];
    logic [M_BITS-1:0]        m_next    [LOG_FRAC_BITS];

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < ENERGY_BITS; i++)
        begin
            if (energy[i])
            begin
                msb_next = MSB_BITS'(i);
            end
        end
    end

    assign shift = MSB_BITS'(ENERGY_BITS - 1) - msba_reg;
    assign norm  = xa_reg << shift;

    always_comb
    begin
        for (int s = 0; s < LOG_FRAC_BITS; s++)
        begin
            sq[s] = m_reg[s] * m_reg[s];
            if (sq[s][2*M_BITS-1])
            begin
                m_next[s] = sq[s][2*M_BITS-1:M_BITS];
            end
            else
            begin
                m_next[s] = sq[s][2*M_BITS-2:M_BITS-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            for (int s = 0; s < LOG_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            va_reg       <= energy_valid;
            valid_reg[0] <= va_reg;
            for (int s = 0; s < LOG_FRAC_BITS; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg      <= energy;
        msba_reg    <= msb_next;
        m_reg[0]    <= norm[ENERGY_BITS-1 -: M_BITS];
        frac_reg[0] <= '0;
        msb_reg[0]  <= msba_reg;
        zero_reg[0] <= (xa_reg == '0);
        for (int s = 0; s < LOG_FRAC_BITS; s++)
        begin
            m_reg[s+1]    <= m_next[s];
            frac_reg[s+1] <= {frac_reg[s][LOG_FRAC_BITS-2:0], sq[s][2*M_BITS-1]};
            msb_reg[s+1]  <= msb_reg[s];
            zero_reg[s+1] <= zero_reg[s];
        end
    end

    assign lane_valid = valid_reg[LOG_STAGES-1];
    assign lane.zero  = zero_reg[LOG_STAGES-1];
    assign lane.level = {msb_reg[LOG_STAGES-1], frac_reg[LOG_STAGES-1]};

endmodule

>>> hw/rtl/bprd_merge.sv
// Merge of the two lanes: log difference, dB scaling, rounding, saturation, status.
module bprd_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              lane_valid,
    input  bprd_pkg::lane_t   lane_a,
    input  bprd_pkg::lane_t   lane_b,
    output logic              res_valid,
    output bprd_pkg::result_t res
);
    import bprd_pkg::*;

    logic                        v1_reg;
    logic signed [DIFF_BITS-1:0] diff_reg;
    logic                        za1_reg;
    logic                        zb1_reg;

    logic                        v2_reg;
    logic [PROD_BITS-1:0]        prod_reg;
    logic                        neg_reg;
    logic                        za2_reg;
    logic                        zb2_reg;

    logic                        res_valid_reg;
    result_t                     res_reg;
    result_t                     res_next;

    logic                        neg;
    logic [DIFF_BITS-1:0]        mag;
    logic [PROD_BITS:0]          rnd;
    logic [R_BITS-1:0]           r;

    assign neg = diff_reg[DIFF_BITS-1];
    assign mag = neg ? (DIFF_BITS'(0) - diff_reg) : diff_reg;
    assign rnd = (PROD_BITS+1)'(prod_reg) + ((PROD_BITS+1)'(1) << (DB_SHIFT - 1));
    assign r   = rnd[PROD_BITS:DB_SHIFT];

    always_comb
    begin
        res_next.status = ST_VALID;
        if (neg_reg)
        begin
            res_next.db = (r > R_NEG_LIMIT) ? OUT_MIN : OUT_BITS'(R_BITS'(0) - r);
        end
        else
        begin
            res_next.db = (r > R_POS_LIMIT) ? OUT_MAX : OUT_BITS'(r);
        end
        if (za2_reg && zb2_reg)
        begin
            res_next.status = ST_BOTH_ZERO;
            res_next.db     = '0;
        end
        else if (za2_reg)
        begin
            res_next.status = ST_A_ZERO;
            res_next.db     = OUT_MIN;
        end
        else if (zb2_reg)
        begin
            res_next.status = ST_B_ZERO;
            res_next.db     = OUT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= lane_valid;
            v2_reg        <= v1_reg;
            res_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= signed'({1'b0, lane_a.level}) - signed'({1'b0, lane_b.level});
        za1_reg  <= lane_a.zero;
        zb1_reg  <= lane_b.zero;
        prod_reg <= mag[LOG_BITS-1:0] * DB_SCALE;
        neg_reg  <= neg;
        za2_reg  <= za1_reg;
        zb2_reg  <= zb1_reg;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> hw/rtl/bprd_out_fifo.sv
// Result queue between the merge stage and the output channel.
module bprd_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bprd_pkg::result_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output bprd_pkg::result_t rd_data
);
    import bprd_pkg::*;

    result_t                slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [CREDIT_BITS-1:0] count_reg;
    logic                   pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/block_power_ratio_db_core.sv
// Top level: sample squaring, energy accumulation, two log2 lanes, merge, result queue.
// A block's result reaches result_valid through the square, energy, log2 lane, merge and queue registers.
// Throughput: one sample word per cycle; input stalls only on a block-ending word while
// 32 results are in flight or queued, set by the 32-entry result queue.
// Reset clears both energy sums, the pair count, the pipeline and the queue, and sets
// block_length to 1024.
module block_power_ratio_db_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    block_length_we,
    input  logic [bprd_pkg::CNT_BITS-1:0]           block_length,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic signed [bprd_pkg::SAMPLE_BITS-1:0] sample_a,
    input  logic signed [bprd_pkg::SAMPLE_BITS-1:0] sample_b,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [bprd_pkg::OUT_BITS-1:0]    power_ratio_db,
    output logic [1:0]                              status
);
    import bprd_pkg::*;

    logic [CNT_BITS-1:0]    block_length_reg;
    logic [CNT_BITS-1:0]    pair_count_reg;
    logic [CNT_BITS-1:0]    pair_count_next;
    logic [CREDIT_BITS-1:0] credit_reg;
    logic [CNT_BITS-1:0]    eff_len;
    logic [CNT_BITS:0]      count_inc;
    logic                   ends_block;
    logic                   accept;
    logic                   reserve;
    logic                   release_slot;

    logic signed [2*SAMPLE_BITS-1:0] prod_a;
    logic signed [2*SAMPLE_BITS-1:0] prod_b;

    logic                   v1_reg;
    logic                   last1_reg;
    logic [SQ_BITS-1:0]     sq_a_reg;
    logic [SQ_BITS-1:0]     sq_b_reg;

    logic [ENERGY_BITS-1:0] acc_a_reg;
    logic [ENERGY_BITS-1:0] acc_b_reg;
    logic [ENERGY_BITS:0]   sum_a;
    logic [ENERGY_BITS:0]   sum_b;
    logic [ENERGY_BITS-1:0] sat_a;
    logic [ENERGY_BITS-1:0] sat_b;

    logic                   ev_reg;
    logic [ENERGY_BITS-1:0] energy_a_reg;
    logic [ENERGY_BITS-1:0] energy_b_reg;

    logic                   lane_a_valid;
    logic                   lane_b_valid;
    lane_t                  lane_a;
    lane_t                  lane_b;
    logic                   res_valid;
    result_t                res;
    result_t                out_word;

    assign eff_len      = (block_length_reg == '0) ? CNT_BITS'(1) : block_length_reg;
    assign count_inc    = (CNT_BITS+1)'(pair_count_reg) + 1'b1;
    assign ends_block   = (count_inc >= (CNT_BITS+1)'(eff_len));
    assign sample_ready = !ends_block || (credit_reg != CREDIT_BITS'(FIFO_DEPTH));
    assign accept       = sample_valid && sample_ready;
    assign reserve      = accept && ends_block;
    assign release_slot = result_valid && result_ready;
    assign pair_count_next = ends_block ? '0 : count_inc[CNT_BITS-1:0];

    assign prod_a = sample_a * sample_a;
    assign prod_b = sample_b * sample_b;

    assign sum_a = (ENERGY_BITS+1)'(acc_a_reg) + (ENERGY_BITS+1)'(sq_a_reg);
    assign sum_b = (ENERGY_BITS+1)'(acc_b_reg) + (ENERGY_BITS+1)'(sq_b_reg);
    assign sat_a = sum_a[ENERGY_BITS] ? ENERGY_MAX : sum_a[ENERGY_BITS-1:0];
    assign sat_b = sum_b[ENERGY_BITS] ? ENERGY_MAX : sum_b[ENERGY_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LEN_RESET;
            pair_count_reg   <= '0;
            credit_reg       <= '0;
            v1_reg           <= 1'b0;
            last1_reg        <= 1'b0;
            acc_a_reg        <= '0;
            acc_b_reg        <= '0;
            ev_reg           <= 1'b0;
        end
        else
        begin
            if (block_length_we)
            begin
                block_length_reg <= block_length;
            end
            if (accept)
            begin
                pair_count_reg <= pair_count_next;
            end
            if (reserve && !release_slot)
            begin
                credit_reg <= credit_reg + 1'b1;
            end
            else if (release_slot && !reserve)
            begin
                credit_reg <= credit_reg - 1'b1;
            end
            v1_reg    <= accept;
            last1_reg <= reserve;
            ev_reg    <= v1_reg && last1_reg;
            // clear the sums at the end of a block
            if (v1_reg)
            begin
                if (last1_reg)
                begin
                    acc_a_reg <= '0;
                    acc_b_reg <= '0;
                end
                else
                begin
                    acc_a_reg <= sat_a;
                    acc_b_reg <= sat_b;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_a_reg <= prod_a[SQ_BITS-1:0];
            sq_b_reg <= prod_b[SQ_BITS-1:0];
        end
        energy_a_reg <= sat_a;
        energy_b_reg <= sat_b;
    end

    bprd_log2_lane u_lane_a (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_valid (ev_reg),
        .energy       (energy_a_reg),
        .lane_valid   (lane_a_valid),
        .lane         (lane_a)
    );

    bprd_log2_lane u_lane_b (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_valid (ev_reg),
        .energy       (energy_b_reg),
        .lane_valid   (lane_b_valid),
        .lane         (lane_b)
    );

    bprd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_a_valid && lane_b_valid),
        .lane_a     (lane_a),
        .lane_b     (lane_b),
        .res_valid  (res_valid),
        .res        (res)
    );

    bprd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_valid (result_valid),
        .rd_ready (result_ready),
        .rd_data  (out_word)
    );

    assign power_ratio_db = out_word.db;
    assign status         = out_word.status;

endmodule

>>> sim/tb_block_power_ratio_db_core.sv
// Testbench for block_power_ratio_db_core: directed and random sample words checked by a scoreboard.
localparam bit [63:0] DB_STEP_Q16 = 64'd3156528;
localparam bit [63:0] HALF_STEP = 64'd1 << 35;
localparam int DB_SHIFT_BITS = 36;
localparam int LOG_FRAC = 20;
localparam bit [63:0] SUM_LIMIT = (64'd1 << 43) - 64'd1;
localparam logic signed [11:0] DB_CEIL = 12'sh7FF;
localparam logic signed [11:0] DB_FLOOR = 12'sh800;

class ratio_scoreboard;
    bit [63:0] sum_a;
    bit [63:0] sum_b;
    bit [12:0] pair_total;
    bit [12:0] blk_len;
    bprd_pkg::result_t due_results[$];
    int words_in;
    int results_in;
    int errors;
    int status_seen[4];
    int clip_hi;
    int clip_lo;

    function new();
        blk_len = bprd_pkg::BLOCK_LEN_RESET;
    endfunction

    function void set_length(bit [12:0] len_value);
        blk_len = len_value;
    endfunction

    function bit [63:0] add_energy(bit [63:0] acc, logic signed [15:0] s);
        bit [63:0] total;
        total = acc + 64'(longint'(s) * longint'(s));
        return (total > SUM_LIMIT) ? SUM_LIMIT : total;
    endfunction

    function longint log2_q20(bit [63:0] x);
        int msb;
        bit [63:0] m;
        bit [63:0] sq;
        longint acc;
        msb = 63;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        acc = msb;
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            sq = m * m;
            acc = acc * 2;
            if (sq[63])
            begin
                acc = acc + 1;
                m = sq >> 32;
            end
            else
            begin
                m = sq >> 31;
            end
        end
        return acc;
    endfunction

    function logic signed [bprd_pkg::OUT_BITS-1:0] db_of_ratio(bit [63:0] num, bit [63:0] den);
        longint diff;
        bit [63:0] mag;
        bit [63:0] steps;
        diff = log2_q20(num) - log2_q20(den);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        steps = (mag * DB_STEP_Q16 + HALF_STEP) >> DB_SHIFT_BITS;
        if (diff < 0)
            return (steps >= 64'd2048) ? DB_FLOOR : 12'(-steps);
        return (steps > 64'd2047) ? DB_CEIL : 12'(steps);
    endfunction

    function void note_pair(logic signed [15:0] a, logic signed [15:0] b);
        bprd_pkg::result_t r;
        bit [12:0] len;
        words_in++;
        sum_a = add_energy(sum_a, a);
        sum_b = add_energy(sum_b, b);
        pair_total = pair_total + 13'd1;
        len = (blk_len == 13'd0) ? 13'd1 : blk_len;
        if (pair_total < len)
            return;
        if (sum_a == 0 && sum_b == 0)
        begin
            r.status = bprd_pkg::ST_BOTH_ZERO;
            r.db = '0;
        end
        else if (sum_a == 0)
        begin
            r.status = bprd_pkg::ST_A_ZERO;
            r.db = DB_FLOOR;
        end
        else if (sum_b == 0)
        begin
            r.status = bprd_pkg::ST_B_ZERO;
            r.db = DB_CEIL;
        end
        else
        begin
            r.status = bprd_pkg::ST_VALID;
            r.db = db_of_ratio(sum_a, sum_b);
        end
        due_results.push_back(r);
        sum_a = 0;
        sum_b = 0;
        pair_total = 0;
    endfunction

    task report_mismatch(string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH result %0d: %s", results_in, what);
    endtask

    task check_result(logic signed [11:0] db, logic [1:0] st);
        bprd_pkg::result_t want;
        results_in++;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result db=%0d status=%0d", db, st));
            return;
        end
        want = due_results.pop_front();
        status_seen[want.status]++;
        if (want.status == bprd_pkg::ST_VALID && want.db == DB_CEIL)
            clip_hi++;
        if (want.status == bprd_pkg::ST_VALID && want.db == DB_FLOOR)
            clip_lo++;
        if (db !== want.db)
            report_mismatch($sformatf("power_ratio_db %0d, expected %0d", db, want.db));
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
    endtask
endclass

module tb_block_power_ratio_db_core;
    import bprd_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASES = 11;
    localparam int PHASE_LEN [PHASES] = '{1, 2, 0, 3, 7, 16, 1, 5, 64, 255, 4};
    localparam int PHASE_WORDS [PHASES] = '{120, 120, 80, 120, 112, 128, 80, 120, 128, 255, 124};

    typedef enum int {
        SRC_ZERO,
        SRC_EXTREME,
        SRC_SCALED,
        SRC_FULL
    } sample_src_t;

    logic clk;
    logic rst_n;
    logic block_length_we;
    logic [CNT_BITS-1:0] block_length;
    logic sample_valid;
    logic sample_ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic result_valid;
    logic result_ready;
    logic signed [OUT_BITS-1:0] power_ratio_db;
    logic [1:0] status;

    bit idle_on;
    bit hold_req;
    ratio_scoreboard sb;

    block_power_ratio_db_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .block_length_we (block_length_we),
        .block_length    (block_length),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample_a        (sample_a),
        .sample_b        (sample_b),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .power_ratio_db  (power_ratio_db),
        .status          (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(power_ratio_db, status);
    end

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                result_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    function automatic sample_src_t pick_src();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return SRC_ZERO;
        if (roll == 1)
            return SRC_EXTREME;
        if (roll < 6)
            return SRC_SCALED;
        return SRC_FULL;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(sample_src_t src);
        logic signed [SAMPLE_BITS-1:0] raw;
        raw = SAMPLE_BITS'($urandom);
        case (src)
            SRC_ZERO: return '0;
            SRC_EXTREME: return raw[0] ? 16'sh7FFF : 16'sh8000;
            SRC_SCALED: return raw >>> $urandom_range(1, SAMPLE_BITS - 1);
            default: return raw;
        endcase
    endfunction

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] a,
                             input logic signed [SAMPLE_BITS-1:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_a <= a;
        sample_b <= b;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_pair(a, b);
        @(negedge clk);
    endtask

    task automatic load_length(input logic [CNT_BITS-1:0] len_value);
        block_length_we <= 1'b1;
        block_length <= len_value;
        @(negedge clk);
        block_length_we <= 1'b0;
        sb.set_length(len_value);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CNT_BITS-1:0] len_value, input int words);
        sample_src_t src_a;
        sample_src_t src_b;
        src_a = SRC_FULL;
        src_b = SRC_FULL;
        drain_results();
        load_length(len_value);
        for (int n = 0; n < words; n++)
        begin
            if (sb.pair_total == 0)
            begin
                src_a = pick_src();
                src_b = pick_src();
            end
            send_pair(draw_sample(src_a), draw_sample(src_b));
        end
    endtask

    initial
    begin
        sb = new();
        idle_on = 1'b1;
        hold_req = 1'b0;
        rst_n = 1'b0;
        block_length_we = 1'b0;
        block_length = '0;
        sample_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_length(CNT_BITS'(1));
        send_pair(16'sh7FFF, 16'sh7FFF);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sh8000, 16'sh0001);
        send_pair(16'sh0001, 16'sh8000);
        send_pair(16'sh7FFF, -16'sd1);
        send_pair(-16'sd1, 16'sh7FFF);
        send_pair(16'sh0000, 16'sh0005);
        send_pair(16'sh0007, 16'sh0000);
        send_pair(16'sh0000, 16'sh0000);
        send_pair(16'sh0000, 16'sh8000);
        send_pair(16'sh8000, 16'sh0000);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'sh00FF, 16'shFF00);

        drain_results();
        load_length(CNT_BITS'(0));
        send_pair(16'sd100, 16'sd3);
        send_pair(-16'sd3, 16'sd100);
        send_pair(16'sh0000, 16'sh0000);

        // shorten the block after five pairs are already in
        drain_results();
        load_length(CNT_BITS'(9));
        repeat (5) send_pair(draw_sample(SRC_FULL), draw_sample(SRC_FULL));
        drain_results();
        load_length(CNT_BITS'(2));
        send_pair(16'sh1234, -16'sd77);

        drain_results();
        load_length(CNT_BITS'(3));
        repeat (3) send_pair(16'sh0000, draw_sample(SRC_SCALED));

        for (int p = 0; p < PHASES; p++)
            run_phase(CNT_BITS'(PHASE_LEN[p]), PHASE_WORDS[p]);

        // hold the result side while words keep coming, so the queue fills
        drain_results();
        load_length(CNT_BITS'(1));
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (200) send_pair(draw_sample(SRC_FULL), draw_sample(SRC_SCALED));

        run_phase(CNT_BITS'(1), 60);
        drain_results();

        $display("Covered %0d sample words and %0d results over block lengths 0 to 255.",
                 sb.words_in, sb.results_in);
        $display("Results by status valid/a-zero/b-zero/both: %0d/%0d/%0d/%0d, clipped hi/lo: %0d/%0d.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
                 sb.clip_hi, sb.clip_lo);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
